@@ rtl/bmsc_pkg.sv @@
`default_nettype none

package bmsc_pkg;

	localparam int MAX_SLOTS = 16;
	localparam int MAX_TOTAL = 255;

	localparam int ROW_LEN = MAX_TOTAL + 1;
	localparam int DEPTH   = (MAX_SLOTS + 1) * ROW_LEN;

	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int ROW_W   = $clog2(MAX_SLOTS + 1);
	localparam int COL_W   = $clog2(ROW_LEN);
	localparam int COUNT_W = 64;

	// flat table address of (used slots, partial sum)
	function automatic logic [ADDR_W-1:0] tbl_addr(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		tbl_addr = ADDR_W'(row) * ADDR_W'(ROW_LEN) + ADDR_W'(col);
	endfunction

endpackage

`default_nettype wire

@@ rtl/bmsc_ram.sv @@
`default_nettype none

module bmsc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4352
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic      [WIDTH-1:0]         rdata_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

@@ rtl/bounded_multiset_sum_count_core.sv @@
`default_nettype none

// counts multisets of slot_count values from [value_low, value_high] that sum
// to target_sum, modulo 2^64
//
// request side: an item is taken on a clock edge where start is high and busy
// is low. busy stays high until the answer has been produced.
// result side: multiset_total is valid for exactly one cycle while done is
// high; the receiver cannot stall, so it must capture it in that cycle.
//
// an empty range, slot_count above the table size or a target above the
// table width answers on the next cycle. otherwise the table region in use
// is cleared first, one entry per cycle, then each update of the sweep reads
// in ST_RD and writes in ST_WR on the single read-add-write path of the table
// memory, for v = value_low .. top with top = min(value_high, target_sum);
// ST_FETCH and ST_LOAD then read out the answer.
//
// reset clears the sequencer and the strobe; the table needs no reset since
// every request rebuilds the part it reads.

module bounded_multiset_sum_count_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [4:0]  slot_count,
	input  wire logic [7:0]  target_sum,
	input  wire logic [7:0]  value_low,
	input  wire logic [7:0]  value_high,
	output logic             done,
	output logic [63:0]      multiset_total
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CLEAR = 6'b000010,
		ST_RD    = 6'b000100,
		ST_WR    = 6'b001000,
		ST_FETCH = 6'b010000,
		ST_LOAD  = 6'b100000
	} state_t;

	state_t                            state_q;
	logic                              done_q;
	logic [bmsc_pkg::COUNT_W-1:0]      total_out_q;
	logic [bmsc_pkg::ROW_W-1:0]        slots_q;
	logic [bmsc_pkg::COL_W-1:0]        sum_q;
	logic [bmsc_pkg::COL_W-1:0]        lo_q;
	logic [bmsc_pkg::COL_W-1:0]        top_q;
	logic [bmsc_pkg::ROW_W-1:0]        row_q;
	logic [bmsc_pkg::COL_W-1:0]        col_q;
	logic [bmsc_pkg::COL_W-1:0]        v_q;

	logic [bmsc_pkg::ADDR_W-1:0]       addr_a;
	logic [bmsc_pkg::ADDR_W-1:0]       addr_b;
	logic                              we;
	logic [bmsc_pkg::COUNT_W-1:0]      wdata;
	logic [bmsc_pkg::COUNT_W-1:0]      rd_a;
	logic [bmsc_pkg::COUNT_W-1:0]      rd_b;
	logic                              req_empty;
	logic [7:0]                        req_top;

	always_comb begin
		req_empty = (value_high < value_low) || (int'(slot_count) > bmsc_pkg::MAX_SLOTS)
			|| (int'(target_sum) > bmsc_pkg::MAX_TOTAL);
		req_top = (value_high < target_sum) ? value_high : target_sum;
	end

	// a: entry being updated, b: row below shifted by the current value
	always_comb begin
		addr_a = bmsc_pkg::tbl_addr(row_q, col_q);
		addr_b = bmsc_pkg::tbl_addr(row_q - bmsc_pkg::ROW_W'(1), col_q - v_q);
		we     = (state_q == ST_CLEAR) || (state_q == ST_WR);
		if (state_q == ST_CLEAR) begin
			wdata = (row_q == '0 && col_q == '0) ? bmsc_pkg::COUNT_W'(1) : '0;
		end else begin
			wdata = rd_a + rd_b;
		end
	end

	bmsc_ram #(
		.WIDTH (bmsc_pkg::COUNT_W),
		.DEPTH (bmsc_pkg::DEPTH)
	) u_table (
		.clk     (clk),
		.we      (we),
		.waddr   (addr_a),
		.wdata   (wdata),
		.raddr_a (addr_a),
		.rdata_a (rd_a),
		.raddr_b (addr_b),
		.rdata_b (rd_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			done_q      <= 1'b0;
			total_out_q <= '0;
			slots_q     <= '0;
			sum_q       <= '0;
			lo_q        <= '0;
			top_q       <= '0;
			row_q       <= '0;
			col_q       <= '0;
			v_q         <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						slots_q <= bmsc_pkg::ROW_W'(slot_count);
						sum_q   <= bmsc_pkg::COL_W'(target_sum);
						lo_q    <= bmsc_pkg::COL_W'(value_low);
						top_q   <= bmsc_pkg::COL_W'(req_top);
						if (req_empty) begin
							total_out_q <= '0;
							done_q      <= 1'b1;
						end else begin
							row_q   <= '0;
							col_q   <= '0;
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_CLEAR: begin
					if (col_q == sum_q) begin
						if (row_q == slots_q) begin
							// no update possible: read the answer straight away
							if (slots_q == '0 || lo_q > top_q) begin
								row_q   <= slots_q;
								col_q   <= sum_q;
								state_q <= ST_FETCH;
							end else begin
								row_q   <= bmsc_pkg::ROW_W'(1);
								col_q   <= lo_q;
								v_q     <= lo_q;
								state_q <= ST_RD;
							end
						end else begin
							row_q <= row_q + bmsc_pkg::ROW_W'(1);
							col_q <= '0;
						end
					end else begin
						col_q <= col_q + bmsc_pkg::COL_W'(1);
					end
				end
				ST_RD: begin
					state_q <= ST_WR;
				end
				ST_WR: begin
					if (col_q == sum_q) begin
						if (row_q == slots_q) begin
							if (v_q == top_q) begin
								row_q   <= slots_q;
								col_q   <= sum_q;
								state_q <= ST_FETCH;
							end else begin
								v_q     <= v_q + bmsc_pkg::COL_W'(1);
								row_q   <= bmsc_pkg::ROW_W'(1);
								col_q   <= v_q + bmsc_pkg::COL_W'(1);
								state_q <= ST_RD;
							end
						end else begin
							row_q   <= row_q + bmsc_pkg::ROW_W'(1);
							col_q   <= v_q;
							state_q <= ST_RD;
						end
					end else begin
						col_q   <= col_q + bmsc_pkg::COL_W'(1);
						state_q <= ST_RD;
					end
				end
				ST_FETCH: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					total_out_q <= rd_a;
					done_q      <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != ST_IDLE);
	assign done           = done_q;
	assign multiset_total = total_out_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a request is still running");

	a_update_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WR) |-> (row_q != '0 && row_q <= slots_q && col_q >= v_q
			&& col_q <= sum_q && v_q <= top_q))
		else $error("table update outside the active region");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted item neither started nor answered");

	a_fetch_then_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FETCH) |=> (state_q == ST_LOAD && row_q == slots_q
			&& col_q == sum_q))
		else $error("answer read did not follow its fetch");

endmodule

`default_nettype wire
